### design/mat4mul_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4mul_pkg
// Shared widths, defaults, opcodes and sequencer states of the 4x4 matrix
// multiply unit.
// ----------------------------------------------------------------------------
package mat4mul_pkg;

   localparam int DIM_DEF       = 4;
   localparam int FRAC_BITS_DEF = 16;

   localparam int OP_W    = 2;
   localparam int INDEX_W = 2;   // row / col field width on the channels
   localparam int VALUE_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_B = 2'd1,
      OP_MUL    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

### design/mat4mul_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4mul_req_if
// Request channel: element loads and multiply commands.
// ----------------------------------------------------------------------------
interface mat4mul_req_if import mat4mul_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic [INDEX_W-1:0]        row;
   logic [INDEX_W-1:0]        col;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output op, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input op, input row, input col, input value,
                   output ready);

endinterface

### design/mat4mul_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4mul_rsp_if
// Response channel: product elements in row-major order.
// ----------------------------------------------------------------------------
interface mat4mul_rsp_if import mat4mul_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic [INDEX_W-1:0]        out_row;
   logic [INDEX_W-1:0]        out_col;
   logic signed [VALUE_W-1:0] out_value;
   logic                      last;

   modport source (output valid, output out_row, output out_col, output out_value,
                   output last, input ready);
   modport sink   (input valid, input out_row, input out_col, input out_value,
                   input last, output ready);

endinterface

### design/matrix4x4_multiply_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_multiply_unit
// DIM x DIM signed fixed-point matrix multiply with one shared multiplier
// and accumulator, stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  req_ch  | in  | valid/ready        | op, row, col, value
//  rsp_ch  | out | valid/ready        | out_row, out_col, out_value, last
//
//  A load request writes one entry of A or B. A multiply request returns
//  DIM*DIM responses; each element is a dot product over DIM operand
//  pairs read through the single multiplier, followed by a drain of the
//  read/multiply/accumulate pipe and a load into the response register;
//  backpressure on the response delays the next element. Requests are
//  taken only when idle. Synchronous reset clears both matrices to zero
//  via per-entry valid bits. A stalled response holds its payload until taken.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_unit import mat4mul_pkg::*; #(
   parameter int DIM       = DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   mat4mul_req_if.sink   req_ch,
   mat4mul_rsp_if.source rsp_ch
);

   localparam int ENTRIES = DIM * DIM;
   localparam int RW      = $clog2(DIM);
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int ACC_W   = PROD_W + $clog2(DIM);

   localparam logic [RW-1:0] LAST_IDX = RW'(DIM - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(32'sh8000_0000);

   state_type state_ff, state_in;
   logic [RW-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic          req_ready, rsp_valid, rsp_last;
   logic          acc_clr, out_load;

   // operand stores
   logic signed [VALUE_W-1:0] mem_a [ENTRIES];
   logic signed [VALUE_W-1:0] mem_b [ENTRIES];
   logic [ENTRIES-1:0]        valid_a_ff, valid_b_ff;

   logic                      req_acc, wr_ok, we_a, we_b;
   logic [IDX_W-1:0]          wr_idx, a_addr, b_addr;

   // pipe: read -> multiply -> accumulate
   logic                      rd_vld_ff, prod_vld_ff;
   logic signed [VALUE_W-1:0] a_rd_ff, b_rd_ff, a_op, b_op;
   logic                      a_ok_ff, b_ok_ff;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in, shifted;
   logic signed [VALUE_W-1:0] out_value_ff, sat_value;

   // --- request decode -----------------------------------------------------
   assign req_acc = req_ch.valid && req_ready;
   assign wr_ok   = (int'(req_ch.row) < DIM) && (int'(req_ch.col) < DIM);
   assign wr_idx  = IDX_W'(int'(req_ch.row) * DIM + int'(req_ch.col));
   assign we_a    = req_acc && wr_ok && (op_type'(req_ch.op) == OP_LOAD_A);
   assign we_b    = req_acc && wr_ok && (op_type'(req_ch.op) == OP_LOAD_B);

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wr_idx] <= req_ch.value;
      end
      if (we_b) begin
         mem_b[wr_idx] <= req_ch.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= '0;
         valid_b_ff <= '0;
      end else begin
         if (we_a) begin
            valid_a_ff[wr_idx] <= 1'b1;
         end
         if (we_b) begin
            valid_b_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // --- sequencer ----------------------------------------------------------
   assign rsp_last = (r_ff == LAST_IDX) && (c_ff == LAST_IDX);

   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      acc_clr   = 1'b0;
      out_load  = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid && op_type'(req_ch.op) == OP_MUL) begin
               state_in = ST_READ;
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
               acc_clr  = 1'b1;
            end
         end
         ST_READ: begin
            if (k_ff == LAST_IDX) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to land in the accumulator
            if (!rd_vld_ff && !prod_vld_ff) begin
               out_load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ch.ready) begin
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  acc_clr  = 1'b1;
                  state_in = ST_READ;
                  if (c_ff == LAST_IDX) begin
                     c_in = '0;
                     r_in = r_ff + 1'b1;
                  end else begin
                     c_in = c_ff + 1'b1;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         r_ff        <= '0;
         c_ff        <= '0;
         k_ff        <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         r_ff        <= r_in;
         c_ff        <= c_in;
         k_ff        <= k_in;
         rd_vld_ff   <= (state_ff == ST_READ);
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // --- datapath -----------------------------------------------------------
   assign a_addr = IDX_W'(int'(r_ff) * DIM + int'(k_ff));
   assign b_addr = IDX_W'(int'(k_ff) * DIM + int'(c_ff));

   always_ff @(posedge clock) begin
      a_rd_ff <= mem_a[a_addr];
      b_rd_ff <= mem_b[b_addr];
      a_ok_ff <= valid_a_ff[a_addr];
      b_ok_ff <= valid_b_ff[b_addr];
   end

   // never-written entries read as zero
   assign a_op    = a_ok_ff ? a_rd_ff : '0;
   assign b_op    = b_ok_ff ? b_rd_ff : '0;
   assign prod_in = a_op * b_op;

   always_comb begin
      acc_in = acc_ff;
      if (acc_clr) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   assign shifted = acc_ff >>> FRAC_BITS;

   always_comb begin
      if (shifted > SAT_MAX) begin
         sat_value = SAT_MAX[VALUE_W-1:0];
      end else if (shifted < SAT_MIN) begin
         sat_value = SAT_MIN[VALUE_W-1:0];
      end else begin
         sat_value = shifted[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (out_load) begin
         out_value_ff <= sat_value;
      end
   end

   // --- ports --------------------------------------------------------------
   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid;
   assign rsp_ch.out_row   = INDEX_W'(r_ff);
   assign rsp_ch.out_col   = INDEX_W'(c_ff);
   assign rsp_ch.out_value = out_value_ff;
   assign rsp_ch.last      = rsp_last;

   // --- assertions ---------------------------------------------------------
   a_mul_starts_at_origin: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && op_type'(req_ch.op) == OP_MUL) |=>
      (state_ff == ST_READ && r_ff == '0 && c_ff == '0 && k_ff == '0))
      else $error("multiply request did not start at element zero");

   a_pipe_empty_at_element_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && k_ff == '0) |-> (!rd_vld_ff && !prod_vld_ff))
      else $error("element started with products still in flight");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after final element");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid) |-> (!req_ch.ready && !rd_vld_ff && !prod_vld_ff))
      else $error("request taken or pipe busy while a response is pending");

endmodule
